>>> src/pwe_pkg.sv
// Package for the polyline width extruder: shared constants, the command
// record passed from front to back, and the back-end state type.
// No dependencies.
package pwe_pkg;

  localparam int MAX_LINE_POINTS_DEF  = 65536;
  localparam int NORMAL_FRAC_BITS_DEF = 15;

  localparam int COORD_W = 15;   // input coordinate width
  localparam int CFG_W   = 15;   // half width register
  localparam int PNUM_W  = 16;   // point number
  localparam int VTX_W   = 24;   // Q16.8 vertex coordinate
  localparam int IN_DW   = 32;   // in_tdata, padded to bytes
  localparam int OUT_DW  = 112;  // out_tdata
  localparam int CFG_DW  = 16;   // cfg_data, padded to bytes

  localparam logic [CFG_W-1:0] HALF_WIDTH_RST = 15'd256;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_SEG,
    KIND_SEG_END
  } cmd_kind_t;

  // One unit of back-end work: segment end points and the point numbers
  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  y0;
    logic signed [COORD_W-1:0]  x1;
    logic signed [COORD_W-1:0]  y1;
    logic [PNUM_W-1:0]          num0;
    logic [PNUM_W-1:0]          num1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_MUL,
    ST_OFF,
    ST_EMIT0,
    ST_EMIT1
  } back_state_t;

endpackage

>>> src/polyline_width_extruder.sv
// Top level of the polyline width extruder: half-width register, front end,
// command queue and back end. Depends on pwe_pkg, pwe_front, pwe_queue,
// pwe_back.
//
//  channel | direction | tdata / data                              | tlast / tuser
//  in_     | slave     | point_x, point_y                          | tlast = line_end
//  out_    | master    | point_number, left_x, left_y, right_x/_y  | tlast = last
//  cfg_    | slave     | half_width                                | -
//
// A first point of a line is absorbed by the front end. For a segment the
// back end passes through the idle, length, root (load and 32 steps),
// set-up, NORMAL_FRAC_BITS + 1 divide steps, multiply, offset and emit
// states; a line's last point adds a second emit. A lone point or zero-length
// segment skips root, set-up and divide. Output stalls hold the emit states. A
// two-entry queue lets the front end take points while the back end works.
// Reset is synchronous, active low.
module polyline_width_extruder #(
  parameter int MAX_LINE_POINTS  = pwe_pkg::MAX_LINE_POINTS_DEF,
  parameter int NORMAL_FRAC_BITS = pwe_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [14:0] point_x, [29:15] point_y, [31:30] zero
  input  logic [pwe_pkg::IN_DW-1:0]   in_tdata,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] point_number, [39:16] left_x, [63:40] left_y,
  // [87:64] right_x, [111:88] right_y
  output logic [pwe_pkg::OUT_DW-1:0]  out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  // [14:0] half_width, [15] zero
  input  logic [pwe_pkg::CFG_DW-1:0]  cfg_data
);
  import pwe_pkg::*;

  logic [CFG_W-1:0] half_width_r;
  logic             q_push, q_pop;
  cmd_t             wr_cmd, rd_cmd;
  q_status_t        q_stat;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
    end else if (cfg_valid) begin
      half_width_r <= cfg_data[CFG_W-1:0];
    end
  end

  pwe_front #(.MAX_LINE_POINTS(MAX_LINE_POINTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_cmd     (wr_cmd),
    .q_stat    (q_stat)
  );

  pwe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .pop    (q_pop),
    .rd_cmd (rd_cmd),
    .stat   (q_stat)
  );

  pwe_back #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .q_cmd      (rd_cmd),
    .half_width (half_width_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full)) else $error("command queue overflow");

  // queue never read when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty)) else $error("command queue underflow");

  // input stalls only because the queue is full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full) else $error("input stalled with queue space");

endmodule

>>> src/pwe_front.sv
// Front end: accepts points, holds the previous point of the line and the
// point counter, and issues segment commands. Depends on pwe_pkg.
module pwe_front #(
  parameter int MAX_LINE_POINTS = pwe_pkg::MAX_LINE_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pwe_pkg::IN_DW-1:0] in_tdata,
  input  logic                      in_tlast,
  output logic                      q_push,
  output pwe_pkg::cmd_t             q_cmd,
  input  pwe_pkg::q_status_t        q_stat
);
  import pwe_pkg::*;

  localparam int CW = $clog2(MAX_LINE_POINTS);

  logic                      held_valid_r;
  logic signed [COORD_W-1:0] held_x_r;
  logic signed [COORD_W-1:0] held_y_r;
  logic [CW-1:0]             cnt_r;

  logic                      accept;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic [CW-1:0]             cnt_inc;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && !q_stat.full;
  assign px        = in_tdata[14:0];
  assign py        = in_tdata[29:15];
  // counter saturates at the last position a line may have
  assign cnt_inc   = (cnt_r == CW'(MAX_LINE_POINTS - 1)) ? cnt_r : cnt_r + 1'b1;

  // command build
  always_comb begin
    q_push     = accept && (held_valid_r || in_tlast);
    q_cmd.num0 = PNUM_W'(cnt_r);
    q_cmd.num1 = PNUM_W'(cnt_inc);
    q_cmd.x1   = px;
    q_cmd.y1   = py;
    if (held_valid_r) begin
      q_cmd.kind = in_tlast ? KIND_SEG_END : KIND_SEG;
      q_cmd.x0   = held_x_r;
      q_cmd.y0   = held_y_r;
    end else begin
      // lone point: zero-length segment gives a zero normal
      q_cmd.kind = KIND_SINGLE;
      q_cmd.x0   = px;
      q_cmd.y0   = py;
    end
  end

  // held point and counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_x_r     <= '0;
      held_y_r     <= '0;
      cnt_r        <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        held_valid_r <= 1'b0;
        held_x_r     <= '0;
        held_y_r     <= '0;
        cnt_r        <= '0;
      end else begin
        held_valid_r <= 1'b1;
        held_x_r     <= px;
        held_y_r     <= py;
        if (held_valid_r) begin
          cnt_r <= cnt_inc;
        end
      end
    end
  end

endmodule

>>> src/pwe_queue.sv
// Two-entry command queue between front and back ends.
// Depends on pwe_pkg.
module pwe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pwe_pkg::cmd_t      wr_cmd,
  input  logic               pop,
  output pwe_pkg::cmd_t      rd_cmd,
  output pwe_pkg::q_status_t stat
);
  import pwe_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign rd_cmd     = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> src/pwe_back.sv
// Back end: per segment, square root of the squared length, two divisions
// for the unit normal, offset scaling and vertex emission.
// Depends on pwe_pkg.
module pwe_back #(
  parameter int NORMAL_FRAC_BITS = pwe_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pwe_pkg::q_status_t         q_stat,
  output logic                       q_pop,
  input  pwe_pkg::cmd_t              q_cmd,
  input  logic [pwe_pkg::CFG_W-1:0]  half_width,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pwe_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tlast
);
  import pwe_pkg::*;

  localparam int F    = NORMAL_FRAC_BITS;
  localparam int NW   = F + 32;       // dividend width
  localparam int PW   = F + 16;       // product width
  localparam int SQ_N = 32;           // root bits

  back_state_t state_r, state_nxt;

  cmd_t               cmd_r;
  logic [15:0]        dx_r, dy_r;
  logic [31:0]        rad_r, root_r;
  logic [33:0]        rem_r;
  logic [4:0]         step_r;
  logic [31:0]        remx_r, remy_r;
  logic [F:0]         lowx_r, lowy_r, qx_r, qy_r;
  logic [PW-1:0]      px_r, py_r;
  logic [VTX_W-1:0]   ox_r, oy_r;

  logic               out_tvalid_r;
  logic [OUT_DW-1:0]  out_tdata_r;
  logic               out_tlast_r;

  logic               slot_free, load;
  logic [15:0]        dx, dy;
  logic [14:0]        adx, ady;
  logic [35:0]        t_rem, trial;
  logic [NW-1:0]      numx, numy;
  logic [32:0]        tx, ty, sd;
  logic [PW:0]        rx, ry;
  logic [15:0]        omx, omy;
  logic [COORD_W-1:0] vx, vy;
  logic [VTX_W-1:0]   cx, cy, lx, ly, rxv, ryv;
  logic [PNUM_W-1:0]  vnum;
  logic               vlast;

  assign slot_free  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // deltas and magnitudes
  assign dx  = {cmd_r.x1[14], cmd_r.x1} - {cmd_r.x0[14], cmd_r.x0};
  assign dy  = {cmd_r.y1[14], cmd_r.y1} - {cmd_r.y0[14], cmd_r.y0};
  assign adx = dx_r[15] ? 15'(-dx_r) : dx_r[14:0];
  assign ady = dy_r[15] ? 15'(-dy_r) : dy_r[14:0];

  // square root step, two radicand bits at a time
  assign t_rem = {rem_r, rad_r[31:30]};
  assign trial = 36'({root_r, 2'b01});

  // dividends: |d| << (F+16) plus half the length for rounding
  assign numx = (NW'(ady) << (F + 16)) + NW'(root_r >> 1);
  assign numy = (NW'(adx) << (F + 16)) + NW'(root_r >> 1);
  assign sd   = {1'b0, root_r};
  assign tx   = {remx_r, lowx_r[F]};
  assign ty   = {remy_r, lowy_r[F]};

  // offset rounding
  assign rx  = {1'b0, px_r} + ((PW+1)'(1) << (F - 1));
  assign ry  = {1'b0, py_r} + ((PW+1)'(1) << (F - 1));
  assign omx = rx[F+15:F];
  assign omy = ry[F+15:F];

  // vertex pair for the point being emitted
  always_comb begin
    if (state_r == ST_EMIT1) begin
      vx   = cmd_r.x1;
      vy   = cmd_r.y1;
      vnum = cmd_r.num1;
      vlast = 1'b1;
    end else begin
      vx   = cmd_r.x0;
      vy   = cmd_r.y0;
      vnum = cmd_r.num0;
      vlast = (cmd_r.kind == KIND_SINGLE);
    end
    cx  = {vx[14], vx, 8'h00};
    cy  = {vy[14], vy, 8'h00};
    lx  = cx + ox_r;
    ly  = -(cy + oy_r);
    rxv = cx - ox_r;
    ryv = -(cy - oy_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        // deltas of the new command, not yet registered
        if ((dx == '0) && (dy == '0)) state_nxt = ST_MUL;
        else                          state_nxt = ST_SQRT;
      end
      ST_SQRT:  if (step_r == 5'(SQ_N - 1)) state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV:   if (step_r == 5'(F)) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_OFF;
      ST_OFF:   state_nxt = ST_EMIT0;
      ST_EMIT0: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = (cmd_r.kind == KIND_SEG_END) ? ST_EMIT1 : ST_IDLE;
        end
      end
      ST_EMIT1: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r <= q_cmd;
      end
      ST_LEN: begin
        dx_r   <= dx;
        dy_r   <= dy;
        rad_r  <= '0;
        root_r <= '0;
        rem_r  <= '0;
        step_r <= '0;
        qx_r   <= '0;
        qy_r   <= '0;
      end
      ST_SQRT: begin
        // first pass after ST_LEN loads the squared length
        if (step_r == '0 && root_r == '0 && rem_r == '0 && rad_r == '0) begin
          rad_r <= 32'(adx) * 32'(adx) + 32'(ady) * 32'(ady);
        end else begin
          rad_r  <= rad_r << 2;
          step_r <= step_r + 5'd1;
          if (t_rem >= trial) begin
            rem_r  <= 34'(t_rem - trial);
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r  <= 34'(t_rem);
            root_r <= {root_r[30:0], 1'b0};
          end
        end
      end
      ST_DINIT: begin
        remx_r <= 32'(numx[NW-1:F+1]);
        remy_r <= 32'(numy[NW-1:F+1]);
        lowx_r <= numx[F:0];
        lowy_r <= numy[F:0];
        step_r <= '0;
      end
      ST_DIV: begin
        step_r <= step_r + 5'd1;
        lowx_r <= lowx_r << 1;
        lowy_r <= lowy_r << 1;
        if (tx >= sd) begin
          remx_r <= 32'(tx - sd);
          qx_r   <= {qx_r[F-1:0], 1'b1};
        end else begin
          remx_r <= tx[31:0];
          qx_r   <= {qx_r[F-1:0], 1'b0};
        end
        if (ty >= sd) begin
          remy_r <= 32'(ty - sd);
          qy_r   <= {qy_r[F-1:0], 1'b1};
        end else begin
          remy_r <= ty[31:0];
          qy_r   <= {qy_r[F-1:0], 1'b0};
        end
      end
      ST_MUL: begin
        px_r <= PW'(qx_r) * PW'(half_width);
        py_r <= PW'(qy_r) * PW'(half_width);
      end
      ST_OFF: begin
        // normal x points against dy, normal y along dx
        ox_r <= (!dy_r[15] && dy_r != '0) ? -VTX_W'(omx) : VTX_W'(omx);
        oy_r <= dx_r[15] ? -VTX_W'(omy) : VTX_W'(omy);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {ryv, rxv, ly, lx, vnum};
      out_tlast_r <= vlast;
    end
  end

endmodule

>>> tb/pwe_checker.sv
// Checker for the polyline width extruder: watches the point, vertex and
// half-width channels, predicts each vertex pair and compares it.
// Depends on pwe_pkg for the channel widths.
module pwe_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [pwe_pkg::IN_DW-1:0]   in_tdata,
  input  logic                        in_tlast,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [pwe_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                        out_tlast,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [pwe_pkg::CFG_DW-1:0]  cfg_data,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import pwe_pkg::*;

  localparam int FRAC = NORMAL_FRAC_BITS_DEF;

  typedef struct packed {
    logic [PNUM_W-1:0] pnum;
    logic [VTX_W-1:0]  lx;
    logic [VTX_W-1:0]  ly;
    logic [VTX_W-1:0]  rx;
    logic [VTX_W-1:0]  ry;
    logic              last;
  } vertex_pair_t;

  vertex_pair_t pair_q[$];

  // shadow of the block state
  logic [CFG_W-1:0] hw;
  int               hx, hy, nx, ny;
  bit               held;
  int unsigned      pcount;

  assign pending = pair_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res, probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic int unit_comp(input longint d, input longint unsigned s);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << (FRAC + 16)) + s / 2) / s;
    return (d < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic longint scaled_offset(input int n);
    longint unsigned mag, o;
    mag = (n < 0) ? -longint'(n) : longint'(n);
    o = (mag * hw + (64'd1 << (FRAC - 1))) >> FRAC;
    return (n < 0) ? -longint'(o) : longint'(o);
  endfunction

  function automatic vertex_pair_t extrude(input int unsigned num, input int x, input int y,
                                           input int vx, input int vy, input logic lst);
    vertex_pair_t p;
    longint cx, cy, ox, oy;
    cx = longint'(x) * 256;
    cy = longint'(y) * 256;
    ox = scaled_offset(vx);
    oy = scaled_offset(vy);
    p.pnum = num[PNUM_W-1:0];
    p.lx = VTX_W'(cx + ox);
    p.ly = VTX_W'(-(cy + oy));
    p.rx = VTX_W'(cx - ox);
    p.ry = VTX_W'(-(cy - oy));
    p.last = lst;
    return p;
  endfunction

  task automatic segment_normal(input int x1, input int y1);
    longint dx, dy;
    longint unsigned l2, s;
    dx = longint'(x1) - hx;
    dy = longint'(y1) - hy;
    l2 = dx * dx + dy * dy;
    if (l2 == 0) begin
      nx = 0;
      ny = 0;
    end else begin
      s = root64(l2 << 32);
      nx = unit_comp(-dy, s);
      ny = unit_comp(dx, s);
    end
  endtask

  task automatic clear_line();
    held = 0;
    hx = 0;
    hy = 0;
    nx = 0;
    ny = 0;
    pcount = 0;
  endtask

  task automatic take_point(input int x, input int y, input logic lend);
    if (!held) begin
      if (lend) begin
        pair_q = {pair_q, extrude(pcount, x, y, 0, 0, 1'b1)};
        clear_line();
      end else begin
        hx = x;
        hy = y;
        held = 1;
        nx = 0;
        ny = 0;
      end
    end else begin
      segment_normal(x, y);
      pair_q = {pair_q, extrude(pcount, hx, hy, nx, ny, 1'b0)};
      if (pcount < MAX_LINE_POINTS_DEF - 1) pcount++;
      if (lend) begin
        pair_q = {pair_q, extrude(pcount, x, y, nx, ny, 1'b1)};
        clear_line();
      end else begin
        hx = x;
        hy = y;
      end
    end
  endtask

  // results first, then new points: a point accepted now cannot be out yet
  always @(posedge clk) begin
    vertex_pair_t want, got;
    if (!rst_n) begin
      hw <= HALF_WIDTH_RST;
      errors = 0;
      clear_line();
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[39:16], out_tdata[63:40],
               out_tdata[87:64], out_tdata[111:88], out_tlast};
        if (pair_q.size() == 0) begin
          report("unexpected transaction", longint'(got.pnum), 0);
        end else begin
          want = pair_q.pop_front();
          if (got.pnum != want.pnum) report("point_number", got.pnum, want.pnum);
          if (got.lx != want.lx) report("left_x", got.lx, want.lx);
          if (got.ly != want.ly) report("left_y", got.ly, want.ly);
          if (got.rx != want.rx) report("right_x", got.rx, want.rx);
          if (got.ry != want.ry) report("right_y", got.ry, want.ry);
          if (got.last != want.last) report("last", got.last, want.last);
        end
      end
      if (in_tvalid && in_tready)
        take_point(int'($signed(in_tdata[14:0])), int'($signed(in_tdata[29:15])), in_tlast);
      if (cfg_valid && cfg_ready) hw <= cfg_data[CFG_W-1:0];
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the polyline width extruder testbench: clock, reset, point and
// half-width stimulus, output back-pressure, watchdog and verdict.
// Depends on pwe_pkg, polyline_width_extruder and pwe_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pwe_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE = 120;

  logic                clk, rst_n;
  logic                in_tvalid, in_tready, in_tlast;
  logic [IN_DW-1:0]    in_tdata;
  logic                out_tvalid, out_tready, out_tlast;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_valid, cfg_ready;
  logic [CFG_DW-1:0]   cfg_data;
  int                  errors, pending, quiet;
  bit                  no_gaps;

  polyline_width_extruder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  pwe_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n)
      quiet <= 0;
    else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // output back-pressure: random stall before each result
  initial begin
    int n;
    out_tready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_point(input int x, input int y, input bit lend);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'($urandom_range(0, 3)), 15'(y), 15'(x)};
    in_tlast <= lend;
    do @(posedge clk); while (!in_tready);
  endtask

  // wait for the last pair, then for the back end to fall idle
  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_half_width(input int v);
    cfg_valid <= 1;
    cfg_data <= {1'($urandom_range(0, 1)), 15'(v)};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic int clip(input int v);
    return (v > 16383) ? 16383 : (v < -16384) ? -16384 : v;
  endfunction

  // random polylines, mostly short with nearby points
  task automatic random_lines(input int count);
    int sent, len, px, py, x, y, mode, reach;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      no_gaps = ($urandom_range(0, 3) == 0);
      px = $urandom_range(0, 32767) - 16384;
      py = $urandom_range(0, 32767) - 16384;
      for (int i = 0; i < len; i++) begin
        mode = $urandom_range(0, 9);
        reach = ($urandom_range(0, 1) != 0) ? 4 : 300;
        if (mode <= 5) begin
          x = clip(px + $urandom_range(0, 2 * reach) - reach);
          y = clip(py + $urandom_range(0, 2 * reach) - reach);
        end else if (mode == 6) begin
          x = $urandom_range(0, 32767) - 16384;
          y = $urandom_range(0, 32767) - 16384;
        end else if (mode == 7) begin
          x = px;
          y = py;
        end else begin
          x = ($urandom_range(0, 1) != 0) ? 16383 : -16384;
          y = ($urandom_range(0, 1) != 0) ? 16383 : -16384;
        end
        send_point(x, y, i == len - 1);
        px = x;
        py = y;
        sent++;
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    int widths[5];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    cfg_valid = 0;
    cfg_data = '0;
    no_gaps = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single points, zero-length segment, extremes, axis segments
    send_point(-16384, -16384, 1);
    send_point(16383, 16383, 1);
    send_point(7, -7, 0);
    send_point(7, -7, 1);
    send_point(-16384, -16384, 0);
    send_point(16383, 16383, 0);
    send_point(16383, -16384, 0);
    send_point(16383, -16384, 0);
    send_point(3, 4, 1);
    send_point(5, 5, 0);
    send_point(5, 9, 0);
    send_point(1, 9, 0);
    send_point(0, 0, 1);
    drain();
    set_half_width(32767);
    send_point(-16384, 16383, 1);
    send_point(-16384, 16383, 0);
    send_point(16383, -16384, 0);
    send_point(0, 0, 1);
    drain();
    set_half_width(0);
    send_point(100, -200, 0);
    send_point(-300, 50, 1);
    drain();

    // random phases, each with its own half width
    widths = '{256, 32767, 0, $urandom_range(1, 32766), $urandom_range(1, 2000)};
    foreach (widths[k]) begin
      set_half_width(widths[k]);
      random_lines(230);
      drain();
    end

    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
